// ===== hdl/rtpd_pkg.sv =====
`default_nettype none

package rtpd_pkg;

   // Width of the interval end points and of the prefix values.
   localparam int VALUE_WIDTH = 32;
   // One extra bit so that the length of the full range fits.
   localparam int EXT_WIDTH = VALUE_WIDTH + 1;
   // Bit positions run from 0 up to VALUE_WIDTH.
   localparam int POS_WIDTH = $clog2(EXT_WIDTH);
   // Prefix lengths run from 0 up to VALUE_WIDTH.
   localparam int LEN_WIDTH = 6;

   localparam int REQ_DATA_WIDTH = ((2 * VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_WIDTH = VALUE_WIDTH + LEN_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_WIDTH + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hdl/range_to_prefix_decompose.sv =====
`default_nettype none

// Range-to-prefix decomposition. Each request carries an inclusive interval
// [range_low, range_high] of unsigned 32-bit values, and the block answers with
// the smallest set of aligned prefix blocks that covers it, largest block first,
// and for blocks of equal size the one right of the split point before the one
// left of it. Every result holds the prefix value (the block's top prefix_len
// bits, right aligned) and prefix_len; tlast marks the final result of a
// request. A request with range_low above range_high gets a single result with
// tuser set, tlast set and zero data. The full range gives one result of length
// zero, and a single value one result of length 32. One request is worked on at
// a time and req_tready stays low until its last result has been loaded into the
// output register. The work runs through one shared 33-bit adder under a small
// sequencer: it finds the interval length, scans down the bit positions for its
// most significant bit, places the split point and the two remainders, and then
// walks the bit positions and both sides of each, producing at most one result
// per cycle.

module range_to_prefix_decompose
   import rtpd_pkg::*;
(
   input  wire                             clock,
   input  wire                             reset,

   input  wire                             req_tvalid,
   output logic                            req_tready,
   // range_low [31:0], range_high [63:32]
   input  wire  [REQ_DATA_WIDTH-1:0]       req_tdata,

   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // prefix_bits [31:0], prefix_len [37:32], zero fill [39:38]
   output logic [RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // is_last
   output logic                            rsp_tlast,
   // bad_range
   output logic                            rsp_tuser
);

   typedef enum logic [3:0] {
      IDLE_ST,
      DIFF_ST,
      TINC_ST,
      SCAN_ST,
      ALIGN_ST,
      LREM_ST,
      RREM_ST,
      LCUR_ST,
      EMIT_ST
   } state_type;

   state_type                 state_ff, state_in;

   // Request end points, held for the whole decomposition.
   logic [VALUE_WIDTH-1:0]    lo_ff, lo_in;
   logic [VALUE_WIDTH-1:0]    hi_ff, hi_in;
   // First high - low, then the interval length.
   logic [EXT_WIDTH-1:0]      len_ff, len_in;
   // Current bit position, its one-hot block size, and the mask below it.
   logic [POS_WIDTH-1:0]      pos_ff, pos_in;
   logic [EXT_WIDTH-1:0]      size_ff, size_in;
   logic [EXT_WIDTH-1:0]      mask_ff, mask_in;
   // The right cursor first holds the split point.
   logic [EXT_WIDTH-1:0]      right_cur_ff, right_cur_in;
   logic [EXT_WIDTH-1:0]      left_cur_ff, left_cur_in;
   logic [EXT_WIDTH-1:0]      right_rem_ff, right_rem_in;
   logic [EXT_WIDTH-1:0]      left_rem_ff, left_rem_in;
   // Low for the block right of the split point, high for the left one.
   logic                      side_ff, side_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]    rsp_bits_ff, rsp_bits_in;
   logic [LEN_WIDTH-1:0]      rsp_len_ff, rsp_len_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_bad_ff, rsp_bad_in;

   // Shared adder.
   logic [EXT_WIDTH-1:0]      add_a;
   logic [EXT_WIDTH-1:0]      add_b;
   logic                      add_cin;
   logic [EXT_WIDTH-1:0]      add_sum;

   // Shared shifter that turns a cursor into a right-aligned prefix.
   logic [EXT_WIDTH-1:0]      shift_src;
   logic [EXT_WIDTH-1:0]      shift_out;

   logic                      req_accept;
   logic                      slot_free;
   logic                      bit_set;
   logic [EXT_WIDTH-1:0]      right_rem_next;
   logic [EXT_WIDTH-1:0]      left_rem_next;
   logic                      final_block;

   assign req_accept = req_tvalid && req_tready;
   // The output register can take a result when it is empty or being drained.
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // The adder operands are chosen by the sequencer step. Subtraction is done
   // as the addition of the inverted operand with a carry in.
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      case (state_ff)
         DIFF_ST: begin
            add_a   = {1'b0, hi_ff};
            add_b   = ~{1'b0, lo_ff};
            add_cin = 1'b1;
         end
         TINC_ST: begin
            add_a   = len_ff;
            add_cin = 1'b1;
         end
         ALIGN_ST: begin
            add_a   = {1'b0, lo_ff};
            add_b   = mask_ff;
         end
         LREM_ST: begin
            add_a   = right_cur_ff;
            add_b   = ~{1'b0, lo_ff};
            add_cin = 1'b1;
         end
         RREM_ST: begin
            add_a   = len_ff;
            add_b   = ~left_rem_ff;
            add_cin = 1'b1;
         end
         LCUR_ST: begin
            add_a   = right_cur_ff;
            add_b   = '1;
         end
         EMIT_ST: begin
            if (side_ff) begin
               add_a   = left_cur_ff;
               add_b   = ~size_ff;
               add_cin = 1'b1;
            end else begin
               add_a   = right_cur_ff;
               add_b   = size_ff;
            end
         end
         default: begin
            add_a   = '0;
         end
      endcase
   end

   assign add_sum = add_a + add_b + EXT_WIDTH'(add_cin);

   // The left cursor only ever covers values below the split point, so its
   // top bit is dropped before the shift.
   assign shift_src = side_ff ? {1'b0, left_cur_ff[VALUE_WIDTH-1:0]} : right_cur_ff;
   assign shift_out = shift_src >> pos_ff;

   // Emission bookkeeping: a block is due when its size bit is set in the
   // remainder of the current side, and it is the final one when both
   // remainders are empty once that bit is taken out.
   assign bit_set        = side_ff ? |(left_rem_ff & size_ff) : |(right_rem_ff & size_ff);
   assign right_rem_next = side_ff ? right_rem_ff : (right_rem_ff & ~size_ff);
   assign left_rem_next  = side_ff ? (left_rem_ff & ~size_ff) : left_rem_ff;
   assign final_block    = ((right_rem_next | left_rem_next) == '0);

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      size_in      = size_ff;
      mask_in      = mask_ff;
      right_cur_in = right_cur_ff;
      left_cur_in  = left_cur_ff;
      right_rem_in = right_rem_ff;
      left_rem_in  = left_rem_ff;
      side_in      = side_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bits_in  = rsp_bits_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;

      case (state_ff)
         IDLE_ST: begin
            if (req_accept) begin
               lo_in    = req_tdata[VALUE_WIDTH-1:0];
               hi_in    = req_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
               state_in = DIFF_ST;
            end
         end
         DIFF_ST: begin
            // A negative difference flags an empty interval.
            if (add_sum[EXT_WIDTH-1]) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_bits_in  = '0;
                  rsp_len_in   = '0;
                  rsp_last_in  = 1'b1;
                  rsp_bad_in   = 1'b1;
                  state_in     = IDLE_ST;
               end
            end else begin
               len_in   = add_sum;
               state_in = TINC_ST;
            end
         end
         TINC_ST: begin
            len_in   = add_sum;
            pos_in   = POS_WIDTH'(VALUE_WIDTH);
            size_in  = {1'b1, {VALUE_WIDTH{1'b0}}};
            mask_in  = {1'b0, {VALUE_WIDTH{1'b1}}};
            state_in = SCAN_ST;
         end
         SCAN_ST: begin
            // Walk down to the most significant set bit of the length; the
            // length is never zero, so this stops at bit zero at the latest.
            if (|(len_ff & size_ff)) begin
               state_in = ALIGN_ST;
            end else begin
               pos_in  = pos_ff - POS_WIDTH'(1);
               size_in = size_ff >> 1;
               mask_in = mask_ff >> 1;
            end
         end
         ALIGN_ST: begin
            // Round low up to a multiple of the largest block size.
            right_cur_in = add_sum & ~mask_ff;
            state_in     = LREM_ST;
         end
         LREM_ST: begin
            left_rem_in = add_sum;
            state_in    = RREM_ST;
         end
         RREM_ST: begin
            right_rem_in = add_sum;
            state_in     = LCUR_ST;
         end
         LCUR_ST: begin
            left_cur_in = add_sum;
            side_in     = 1'b0;
            state_in    = EMIT_ST;
         end
         EMIT_ST: begin
            if (bit_set) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_bits_in  = shift_out[VALUE_WIDTH-1:0];
                  rsp_len_in   = LEN_WIDTH'(VALUE_WIDTH) - LEN_WIDTH'(pos_ff);
                  rsp_last_in  = final_block;
                  rsp_bad_in   = 1'b0;
                  right_rem_in = right_rem_next;
                  left_rem_in  = left_rem_next;
                  if (side_ff) begin
                     left_cur_in = add_sum;
                  end else begin
                     right_cur_in = add_sum;
                  end
                  if (final_block) begin
                     state_in = IDLE_ST;
                  end else if (!side_ff) begin
                     side_in = 1'b1;
                  end else begin
                     side_in = 1'b0;
                     pos_in  = pos_ff - POS_WIDTH'(1);
                     size_in = size_ff >> 1;
                  end
               end
            end else if (!side_ff) begin
               side_in = 1'b1;
            end else if (pos_ff == '0) begin
               state_in = IDLE_ST;
            end else begin
               side_in = 1'b0;
               pos_in  = pos_ff - POS_WIDTH'(1);
               size_in = size_ff >> 1;
            end
         end
         default: begin
            state_in = IDLE_ST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_ST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      len_ff       <= len_in;
      pos_ff       <= pos_in;
      size_ff      <= size_in;
      mask_ff      <= mask_in;
      right_cur_ff <= right_cur_in;
      left_cur_ff  <= left_cur_in;
      right_rem_ff <= right_rem_in;
      left_rem_ff  <= left_rem_in;
      side_ff      <= side_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign req_tready = (state_ff == IDLE_ST);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - RSP_FIELD_WIDTH){1'b0}}, rsp_len_ff, rsp_bits_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // An empty-interval result is always the only one of its request.
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("bad range result without last flag or with data");

   // Prefix lengths never exceed the value width.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_len_ff <= LEN_WIDTH'(VALUE_WIDTH)))
      else $error("prefix length above value width");

   // The block size tracks the bit position as a single bit.
   a_size_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN_ST || state_ff == EMIT_ST) |->
         ($onehot(size_ff) && size_ff == (EXT_WIDTH'(1) << pos_ff)))
      else $error("block size out of step with bit position");

   // Every block right of the split point starts on its own size boundary.
   a_right_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT_ST && !side_ff) |->
         ((right_cur_ff & (size_ff - EXT_WIDTH'(1))) == '0))
      else $error("right cursor not aligned to block size");

   // No remainder bit above the current position is left over.
   a_rem_above: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT_ST) |->
         (((right_rem_ff | left_rem_ff) & ~((size_ff << 1) - EXT_WIDTH'(1))) == '0))
      else $error("remainder bits left above current position");

   // An accepted request always starts the sequencer.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == DIFF_ST && !req_tready))
      else $error("request accepted without starting the sequencer");

endmodule

`default_nettype wire
